// File: sv/mf2d_pkg.sv
// mf2d_pkg: shared widths, register codes, pixel type and min helper
// for the streaming square-window minimum filter. No dependencies.
package mf2d_pkg;

    localparam int PIXEL_BITS      = 16;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int RADIUS_REG_BITS = 2;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 13;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_RADIUS_DEF  = 3;

    localparam int RESET_WIDTH     = 640;
    localparam int RESET_HEIGHT    = 480;
    localparam int RESET_RADIUS    = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WIDTH  = 0,
        CFG_HEIGHT = 1,
        CFG_RADIUS = 2
    } t_cfg_index;

    localparam logic CMD_DRAIN = 1'b1;

    typedef logic signed [PIXEL_BITS-1:0] t_pix;

    localparam t_pix PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};

    function automatic t_pix pix_min(input t_pix a, input t_pix b);
        return (b < a) ? b : a;
    endfunction

endpackage

// File: sv/mf2d_ctrl.sv
// mf2d_ctrl: configuration registers, raster position counters and the
// per-beat control word (row selection, column window mask, output flags).
// Depends on mf2d_pkg.
module mf2d_ctrl #(
    parameter int  MAX_WIDTH  = mf2d_pkg::MAX_WIDTH_DEF,
    parameter int  MAX_RADIUS = mf2d_pkg::MAX_RADIUS_DEF,
    parameter type t_req      = logic
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mf2d_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [mf2d_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_accept,
    input  logic                                i_cmd,
    output logic                                o_counted,
    output t_req                                o_req
);
    import mf2d_pkg::*;

    localparam int XB    = $clog2(MAX_WIDTH);
    localparam int WB    = XB + 1;
    localparam int RB    = $clog2(MAX_RADIUS + 1);
    localparam int SLOTS = 2 * MAX_RADIUS;
    localparam int SB    = $clog2(SLOTS);
    localparam int TAPS  = SLOTS + 1;
    localparam int YB    = $clog2((2 ** HEIGHT_REG_BITS) + 2 * MAX_RADIUS + 1);
    localparam int LB    = RB + WB;

    logic [WIDTH_REG_BITS-1:0]  r_width;
    logic [HEIGHT_REG_BITS-1:0] r_height;
    logic [RADIUS_REG_BITS-1:0] r_radius;

    logic [XB-1:0] r_in_col;
    logic [YB-1:0] r_in_row;
    logic [XB-1:0] r_out_col;
    logic [YB-1:0] r_out_row;
    logic [SB-1:0] r_wslot;
    logic [LB-1:0] r_seen;

    logic [WB-1:0]              w_eff;
    logic [HEIGHT_REG_BITS-1:0] h_eff;
    logic [RB-1:0]              r_eff;
    logic [RB:0]                r2;
    logic [LB-1:0]              lag;
    logic                       is_pix;
    logic                       out_en;
    logic                       last;
    logic                       in_wrap;
    logic                       out_wrap;
    logic                       slot_wrap;
    logic                       cfg_hit;
    logic                       restart;
    logic [SLOTS-1:0]           row_mask;
    logic [TAPS-1:0]            hmask;

    // clamp register values to the supported range
    always_comb begin
        w_eff = WB'(r_width);
        if (r_width == '0) begin
            w_eff = WB'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_eff = WB'(MAX_WIDTH);
        end
    end

    assign h_eff = (r_height == '0) ? HEIGHT_REG_BITS'(1) : r_height;
    assign r_eff = (int'(r_radius) > MAX_RADIUS) ? RB'(MAX_RADIUS) : RB'(r_radius);
    assign r2    = {r_eff, 1'b0};
    assign lag   = LB'(r_eff) * LB'(w_eff) + LB'(r_eff);

    assign is_pix    = r_in_row < YB'(h_eff);
    assign o_counted = i_accept && !(is_pix && i_cmd == CMD_DRAIN);

    assign out_en    = (r_seen == lag);
    assign in_wrap   = (WB'(r_in_col) + WB'(1) == w_eff);
    assign out_wrap  = (WB'(r_out_col) + WB'(1) == w_eff);
    assign last      = (r_out_row == YB'(h_eff) - YB'(1)) && out_wrap;
    assign slot_wrap = (int'(r_wslot) + 1 >= int'(r2));
    assign restart   = (i_cfg_we && cfg_hit) || (o_counted && out_en && last);

    always_comb begin
        unique case (i_cfg_index) inside
            CFG_WIDTH, CFG_HEIGHT, CFG_RADIUS: cfg_hit = 1'b1;
            default:                           cfg_hit = 1'b0;
        endcase
    end

    // row y-j sits in slot (y - j) mod 2R; keep rows inside the frame and
    // no further back than 2R
    always_comb begin
        int s;
        s        = 0;
        row_mask = '0;
        for (int j = 1; j <= SLOTS; j++) begin
            if (j <= int'(r2) && YB'(j) <= r_in_row &&
                r_in_row < YB'(h_eff) + YB'(j)) begin
                s = int'(r_wslot) + int'(r2) - j;
                if (s >= int'(r2)) begin
                    s = s - int'(r2);
                end
                row_mask[s[SB-1:0]] = 1'b1;
            end
        end
    end

    // tap i of the column-minimum line is column out_col + R - i; keep the
    // taps that fall inside the current row
    always_comb begin
        int t;
        t     = int'(r_out_col) + int'(r_eff);
        hmask = '0;
        for (int i = 0; i < TAPS; i++) begin
            hmask[i] = (i <= int'(r2)) && (i <= t) && (t - i < int'(w_eff));
        end
    end

    always_comb begin
        o_req          = '0;
        o_req.addr     = r_in_col;
        o_req.row_mask = row_mask;
        o_req.pix_inc  = is_pix;
        o_req.wr_en    = is_pix && (r_eff != '0);
        o_req.wslot    = r_wslot;
        o_req.h.out_en = out_en;
        o_req.h.last   = last;
        o_req.h.hmask  = hmask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_REG_BITS'(RESET_WIDTH);
            r_height <= HEIGHT_REG_BITS'(RESET_HEIGHT);
            r_radius <= RADIUS_REG_BITS'(RESET_RADIUS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data[WIDTH_REG_BITS-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[HEIGHT_REG_BITS-1:0];
                CFG_RADIUS: r_radius <= i_cfg_data[RADIUS_REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_wslot   <= '0;
            r_seen    <= '0;
        end else if (o_counted) begin
            if (in_wrap) begin
                r_in_col <= '0;
                r_in_row <= r_in_row + YB'(1);
                r_wslot  <= slot_wrap ? '0 : r_wslot + SB'(1);
            end else begin
                r_in_col <= r_in_col + XB'(1);
            end
            if (!out_en) begin
                r_seen <= r_seen + LB'(1);
            end else if (out_wrap) begin
                r_out_col <= '0;
                r_out_row <= r_out_row + YB'(1);
            end else begin
                r_out_col <= r_out_col + XB'(1);
            end
        end
    end

endmodule

// File: sv/mf2d_col_store.sv
// mf2d_col_store: line memory holding the last 2R rows, one word of 2R pixels
// per column, read-modify-write per beat, and the vertical minimum.
// Depends on mf2d_pkg.
module mf2d_col_store #(
    parameter int  MAX_WIDTH  = mf2d_pkg::MAX_WIDTH_DEF,
    parameter int  MAX_RADIUS = mf2d_pkg::MAX_RADIUS_DEF,
    parameter type t_req      = logic,
    parameter type t_hctl     = logic
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  t_req           i_req,
    input  mf2d_pkg::t_pix i_pixel,
    output logic           o_free,
    output logic           o_valid,
    input  logic           i_ready,
    output mf2d_pkg::t_pix o_col_min,
    output t_hctl          o_hctl
);
    import mf2d_pkg::*;

    localparam int SLOTS     = 2 * MAX_RADIUS;
    localparam int SB        = $clog2(SLOTS);
    localparam int WORD_BITS = SLOTS * PIXEL_BITS;

    logic [WORD_BITS-1:0] r_mem [MAX_WIDTH];
    logic [WORD_BITS-1:0] r_rdata;
    logic [WORD_BITS-1:0] r_byp_word;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] wdata;

    t_req r_s1;
    t_pix r_s1_pix;
    logic r_s1_v;
    logic r_byp;
    logic s1_go;

    assign s1_go   = r_s1_v && i_ready;
    assign o_free  = !r_s1_v || i_ready;
    assign o_valid = r_s1_v;
    assign o_hctl  = r_s1.h;

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1.wr_en) begin
            r_mem[r_s1.addr] <= wdata;
        end
        if (i_load) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    // a read issued on the edge that writes the same column sees old data;
    // keep the written word to use instead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_byp  <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_v <= 1'b1;
                r_byp  <= s1_go && r_s1.wr_en && (r_s1.addr == i_req.addr);
            end else if (s1_go) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1       <= i_req;
            r_s1_pix   <= i_pixel;
            r_byp_word <= wdata;
        end
    end

    always_comb begin
        t_pix v;
        t_pix m;
        word  = r_byp ? r_byp_word : r_rdata;
        m     = r_s1.pix_inc ? r_s1_pix : PIX_MAX;
        wdata = word;
        for (int s = 0; s < SLOTS; s++) begin
            v = t_pix'(word[s*PIXEL_BITS +: PIXEL_BITS]);
            if (r_s1.row_mask[s]) begin
                m = pix_min(m, v);
            end
            if (SB'(s) == r_s1.wslot) begin
                wdata[s*PIXEL_BITS +: PIXEL_BITS] = r_s1_pix;
            end
        end
        o_col_min = m;
    end

endmodule

// File: sv/mf2d_row_min.sv
// mf2d_row_min: tapped line of column minima, masked horizontal minimum and
// the output register. Depends on mf2d_pkg.
module mf2d_row_min #(
    parameter int  MAX_RADIUS = mf2d_pkg::MAX_RADIUS_DEF,
    parameter type t_hctl     = logic
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mf2d_pkg::t_pix i_col_min,
    input  t_hctl          i_hctl,
    output logic           o_valid,
    input  logic           i_ready,
    output mf2d_pkg::t_pix o_min_value,
    output logic           o_frame_last
);
    import mf2d_pkg::*;

    localparam int TAPS = 2 * MAX_RADIUS + 1;

    t_pix  r_line [TAPS];
    t_hctl r_s2;
    logic  r_s2_v;
    logic  r_o_valid;
    t_pix  r_o_min;
    logic  r_o_last;
    logic  s2_go;
    logic  push;
    t_pix  hmin;

    // beats without a result pass straight through
    assign s2_go   = r_s2_v && (!r_s2.out_en || !r_o_valid || i_ready);
    assign o_ready = !r_s2_v || s2_go;
    assign push    = i_valid && o_ready;

    always_comb begin
        hmin = PIX_MAX;
        for (int i = 0; i < TAPS; i++) begin
            if (r_s2.hmask[i]) begin
                hmin = pix_min(hmin, r_line[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (push) begin
                r_s2_v <= 1'b1;
            end else if (s2_go) begin
                r_s2_v <= 1'b0;
            end
            if (s2_go && r_s2.out_en) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_line[0] <= i_col_min;
            for (int i = 1; i < TAPS; i++) begin
                r_line[i] <= r_line[i-1];
            end
            r_s2 <= i_hctl;
        end
        if (s2_go && r_s2.out_en) begin
            r_o_min  <= hmin;
            r_o_last <= r_s2.last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_min_value  = r_o_min;
    assign o_frame_last = r_o_last;

endmodule

// File: sv/min_filter_2d.sv
// min_filter_2d: raster-order square-window minimum (erosion), replicate border.
// Throughput one beat per clock while not stalled; the line memory does one read
// and one write per column per cycle. A result reaches the output register after
// the beat completing its window, which lags its pixel by R rows plus R pixels.
// Reset: counters cleared, registers to 640 x 480, radius 3; line memory not
// cleared. Depends on mf2d_pkg, mf2d_ctrl, mf2d_col_store, mf2d_row_min.
module min_filter_2d #(
    parameter int MAX_WIDTH  = mf2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = mf2d_pkg::MAX_RADIUS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_cmd,
    input  mf2d_pkg::t_pix                      i_pixel_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output mf2d_pkg::t_pix                      o_min_value,
    output logic                                o_frame_last,
    input  logic                                i_cfg_we,
    input  logic [mf2d_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [mf2d_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import mf2d_pkg::*;

    localparam int XB    = $clog2(MAX_WIDTH);
    localparam int SLOTS = 2 * MAX_RADIUS;
    localparam int SB    = $clog2(SLOTS);
    localparam int TAPS  = SLOTS + 1;

    typedef struct packed {
        logic            out_en;
        logic            last;
        logic [TAPS-1:0] hmask;
    } t_hctl;

    typedef struct packed {
        logic [XB-1:0]    addr;
        logic [SLOTS-1:0] row_mask;
        logic             pix_inc;
        logic             wr_en;
        logic [SB-1:0]    wslot;
        t_hctl            h;
    } t_req;

    logic  accept;
    logic  counted;
    t_req  req;
    logic  s1_free;
    logic  s1_valid;
    logic  s2_ready;
    t_pix  col_min;
    t_hctl s1_hctl;

    assign o_ready = s1_free;
    assign accept  = i_valid && o_ready;

    mf2d_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .t_req      (t_req)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_cmd       (i_cmd),
        .o_counted   (counted),
        .o_req       (req)
    );

    mf2d_col_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .t_req      (t_req),
        .t_hctl     (t_hctl)
    ) u_col_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (counted),
        .i_req     (req),
        .i_pixel   (i_pixel_value),
        .o_free    (s1_free),
        .o_valid   (s1_valid),
        .i_ready   (s2_ready),
        .o_col_min (col_min),
        .o_hctl    (s1_hctl)
    );

    mf2d_row_min #(
        .MAX_RADIUS (MAX_RADIUS),
        .t_hctl     (t_hctl)
    ) u_row_min (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s1_valid),
        .o_ready      (s2_ready),
        .i_col_min    (col_min),
        .i_hctl       (s1_hctl),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_min_value  (o_min_value),
        .o_frame_last (o_frame_last)
    );

    // the centre column is always inside the horizontal window
    a_window_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_valid |-> s1_hctl.hmask != '0)
        else $error("empty horizontal window");

    // the frame's final result restarts the raster counters
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        counted && req.h.out_en && req.h.last |=> req.addr == '0 && req.wslot == '0)
        else $error("counters not restarted after final result");

    // a result only appears behind a beat that went through the line memory
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(s1_valid, 2))
        else $error("result without a preceding beat");

endmodule

// File: sim/min_filter_2d_test.sv
`timescale 1ns / 1ps
// min_filter_2d_test: self-checking bench for the streaming square-window minimum filter.
// A queue-fed valid/ready driver and a clocked monitor check against an in-bench erosion predictor.
// Depends on mf2d_pkg and min_filter_2d.
module min_filter_2d_test;
    import mf2d_pkg::*;

    localparam logic CMD_PIXEL    = 1'b0;
    localparam int   LINE_SLOTS   = 2 * MAX_RADIUS_DEF;
    localparam int   COLMIN_SLOTS = MAX_RADIUS_DEF + 1;
    localparam int   LONG_HOLD    = 400;
    localparam int   QUIET_LIMIT  = 4000;
    localparam int   SETTLE       = 12;

    typedef struct {
        logic        cmd;
        t_pix        value;
        int unsigned gap;
    } t_pixel_beat;

    typedef struct {
        t_pix min_value;
        logic frame_last;
    } t_min_beat;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      o_ready;
    logic                      i_cmd         = CMD_PIXEL;
    t_pix                      i_pixel_value = '0;
    logic                      o_valid;
    logic                      i_ready       = 1'b0;
    t_pix                      o_min_value;
    logic                      o_frame_last;
    logic                      i_cfg_we      = 1'b0;
    t_cfg_index                i_cfg_index   = CFG_WIDTH;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data    = '0;

    min_filter_2d u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_pixel_value (i_pixel_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_min_value   (o_min_value),
        .o_frame_last  (o_frame_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor
    t_pix                       line_mem   [LINE_SLOTS*MAX_WIDTH_DEF];
    t_pix                       colmin_mem [COLMIN_SLOTS*MAX_WIDTH_DEF];
    int unsigned                in_col, in_row, out_col, out_row;
    logic [WIDTH_REG_BITS-1:0]  cfg_width;
    logic [HEIGHT_REG_BITS-1:0] cfg_height;
    logic [RADIUS_REG_BITS-1:0] cfg_radius;

    function automatic void erode_reset();
        int i;
        for (i = 0; i < LINE_SLOTS * MAX_WIDTH_DEF; i++) line_mem[i] = '0;
        for (i = 0; i < COLMIN_SLOTS * MAX_WIDTH_DEF; i++) colmin_mem[i] = '0;
        cfg_width  = WIDTH_REG_BITS'(RESET_WIDTH);
        cfg_height = HEIGHT_REG_BITS'(RESET_HEIGHT);
        cfg_radius = RADIUS_REG_BITS'(RESET_RADIUS);
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void erode_cfg(input t_cfg_index idx, input logic [CFG_DATA_BITS-1:0] d);
        case (idx)
            CFG_WIDTH:  cfg_width  = d[WIDTH_REG_BITS-1:0];
            CFG_HEIGHT: cfg_height = d[HEIGHT_REG_BITS-1:0];
            CFG_RADIUS: cfg_radius = d[RADIUS_REG_BITS-1:0];
            default: return;
        endcase
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // One accepted beat; returns 1 when it releases a result.
    function automatic bit erode_step(input logic cmd, input t_pix pix,
                                      output t_pix mn, output logic last);
        int unsigned w, h, r, y, x, first_row, last_row, k, c, lo, hi, lag;
        t_pix m, v;
        mn   = '0;
        last = 1'b0;
        w = cfg_width;
        h = cfg_height;
        r = cfg_radius;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        if (h < 1) h = 1;
        if (r > MAX_RADIUS_DEF) r = MAX_RADIUS_DEF;

        // drain while the frame is still coming in: dropped
        if (in_row < h && cmd == CMD_DRAIN) return 0;

        y = in_row;
        x = in_col;
        // column minimum for centre row y - r; rows past the bottom edge are clipped
        if (y >= r && y - r < h) begin
            first_row = (y >= 2 * r) ? y - 2 * r : 0;
            last_row  = (y < h) ? y : h - 1;
            m = PIX_MAX;
            for (k = first_row; k <= last_row; k++) begin
                if (k == y || r == 0) v = pix;
                else v = line_mem[(k % (2 * r)) * MAX_WIDTH_DEF + x];
                if (v < m) m = v;
            end
            colmin_mem[((y - r) % COLMIN_SLOTS) * MAX_WIDTH_DEF + x] = m;
        end
        if (y < h && r > 0) line_mem[(y % (2 * r)) * MAX_WIDTH_DEF + x] = pix;

        in_col = x + 1;
        if (in_col >= w) begin
            in_col = 0;
            in_row = y + 1;
        end

        lag = r * w + r;
        if (y * w + x < lag) return 0;

        lo = (out_col >= r) ? out_col - r : 0;
        hi = out_col + r;
        if (hi > w - 1) hi = w - 1;
        m = PIX_MAX;
        for (c = lo; c <= hi; c++) begin
            v = colmin_mem[(out_row % COLMIN_SLOTS) * MAX_WIDTH_DEF + c];
            if (v < m) m = v;
        end
        last = (out_row == h - 1 && out_col == w - 1);
        mn   = m;
        if (last) begin
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        return 1;
    endfunction

    // ---------------------------------------------------------------- driver
    t_pixel_beat pixel_q [$];
    t_pixel_beat tx_beat;
    int unsigned tx_idle = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_idle <= 0;
        end else if (!i_valid || o_ready) begin
            if (tx_idle > 0) begin
                i_valid <= 1'b0;
                tx_idle <= tx_idle - 1;
            end else if (pixel_q.size() != 0) begin
                tx_beat = pixel_q.pop_front();
                i_valid       <= 1'b1;
                i_cmd         <= tx_beat.cmd;
                i_pixel_value <= tx_beat.value;
                tx_idle       <= tx_beat.gap;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver
    bit          idle_on = 1'b1;
    int unsigned rx_wait = 0;
    int unsigned rx_draw;
    int unsigned rx_hold_req = 0;
    int unsigned rx_holds_done = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait <= 0;
        end else if (rx_holds_done != rx_hold_req) begin
            // long hold so the block backs up into its input
            rx_holds_done <= rx_hold_req;
            rx_wait       <= LONG_HOLD;
            i_ready       <= 1'b0;
        end else if (o_valid && i_ready) begin
            rx_draw = idle_on ? $urandom_range(0, 10) : 0;
            if (rx_draw == 0) begin
                i_ready <= 1'b1;
                rx_wait <= 0;
            end else begin
                i_ready <= 1'b0;
                rx_wait <= rx_draw - 1;
            end
        end else if (rx_wait > 0) begin
            i_ready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- monitor
    t_min_beat   min_exp_q [$];
    t_min_beat   want;
    t_pix        pred_min;
    logic        pred_last;
    int unsigned beats_in = 0;
    int unsigned beats_queued = 0;
    int unsigned mismatches = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (min_exp_q.size() == 0) begin
                    $error("result beat with none expected: min_value %0d frame_last %0b",
                           o_min_value, o_frame_last);
                    mismatches++;
                end else begin
                    want = min_exp_q.pop_front();
                    if (o_min_value !== want.min_value) begin
                        $error("min_value expected %0d actual %0d", want.min_value, o_min_value);
                        mismatches++;
                    end
                    if (o_frame_last !== want.frame_last) begin
                        $error("frame_last expected %0b actual %0b",
                               want.frame_last, o_frame_last);
                        mismatches++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                beats_in++;
                if (erode_step(i_cmd, i_pixel_value, pred_min, pred_last)) begin
                    want.min_value  = pred_min;
                    want.frame_last = pred_last;
                    min_exp_q.push_back(want);
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- stimulus
    bit          noise_on = 1'b0;
    int unsigned work_beats = 0;

    function automatic t_pix draw_pixel();
        t_pix v;
        case ($urandom_range(0, 7))
            0: v = 16'sh8000;
            1: v = 16'sh7FFF;
            2, 3: begin
                // narrow spread so windows hold ties
                v = t_pix'($urandom_range(0, 16));
                v = v - 16'sd8;
            end
            default: v = t_pix'($urandom);
        endcase
        return v;
    endfunction

    function automatic void queue_beat(input logic cmd, input t_pix v);
        t_pixel_beat b;
        b.cmd   = cmd;
        b.value = v;
        b.gap   = idle_on ? $urandom_range(0, 10) : 0;
        pixel_q.push_back(b);
        beats_queued++;
    endfunction

    // Whole frame plus the drains that flush it; cut_short stops part way.
    function automatic void queue_frame(input int unsigned w, input int unsigned h,
                                        input int unsigned r, input bit cut_short);
        int unsigned ew, eh, n, stop_at, pixels, i;
        ew = (w == 0) ? 1 : (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
        eh = (h == 0) ? 1 : h;
        pixels  = ew * eh;
        n       = pixels + r * ew + r;
        stop_at = cut_short ? $urandom_range(0, n - 1) : n;
        for (i = 0; i < stop_at; i++) begin
            if (i < pixels) begin
                if (noise_on && $urandom_range(0, 19) == 0)
                    queue_beat(CMD_DRAIN, t_pix'($urandom));
                queue_beat(CMD_PIXEL, draw_pixel());
            end else begin
                // a pixel beat past the frame's end flushes like a drain
                queue_beat(($urandom_range(0, 3) == 0) ? CMD_PIXEL : CMD_DRAIN,
                           t_pix'($urandom));
            end
            work_beats++;
        end
    endfunction

    task automatic wait_idle();
        while (beats_in != beats_queued || min_exp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_geometry(input logic [WIDTH_REG_BITS-1:0] w,
                                input logic [HEIGHT_REG_BITS-1:0] h,
                                input logic [RADIUS_REG_BITS-1:0] r);
        logic [CFG_DATA_BITS-1:0] d [3];
        t_cfg_index               idx [3];
        logic [1:0]               junk_w;
        logic [10:0]              junk_r;
        junk_w = 2'($urandom);
        junk_r = 11'($urandom);
        // unused upper data bits carry junk
        d[0]   = {junk_w, w};
        d[1]   = h;
        d[2]   = {junk_r, r};
        idx[0] = CFG_WIDTH;
        idx[1] = CFG_HEIGHT;
        idx[2] = CFG_RADIUS;
        for (int i = 0; i < 3; i++) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= d[i];
            erode_cfg(idx[i], d[i]);
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        logic [WIDTH_REG_BITS-1:0]  w;
        logic [HEIGHT_REG_BITS-1:0] h;
        logic [RADIUS_REG_BITS-1:0] r;
        int unsigned                frames;
        erode_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset geometry is 640x480, R=3: these few beats must release nothing
        queue_beat(CMD_PIXEL, 16'sh7FFF);
        queue_beat(CMD_PIXEL, 16'sh8000);
        queue_beat(CMD_DRAIN, 16'sh0000);
        wait_idle();

        // 3x2, R=1: extremes, early drain dropped, pixel beat used as drain
        set_geometry(3, 2, 1);
        queue_beat(CMD_DRAIN, 16'sh1111);
        queue_beat(CMD_PIXEL, 16'sh8000);
        queue_beat(CMD_PIXEL, 16'sh7FFF);
        queue_beat(CMD_PIXEL, 16'sh0000);
        queue_beat(CMD_PIXEL, 16'shFFFF);
        queue_beat(CMD_PIXEL, 16'sh0001);
        queue_beat(CMD_PIXEL, 16'sh7FFF);
        queue_beat(CMD_DRAIN, 16'sh0000);
        queue_beat(CMD_DRAIN, 16'sh0000);
        queue_beat(CMD_DRAIN, 16'sh0000);
        queue_beat(CMD_PIXEL, 16'sh8000);
        wait_idle();

        // single pixel, R=0: result on the same beat, marked last
        set_geometry(1, 1, 0);
        queue_beat(CMD_PIXEL, 16'sh1234);
        wait_idle();

        // window wider and taller than the frame
        set_geometry(2, 1, 2);
        queue_beat(CMD_PIXEL, 16'sh7FFF);
        queue_beat(CMD_PIXEL, 16'sh8000);
        repeat (6) queue_beat(CMD_DRAIN, 16'sh0000);
        wait_idle();

        // back-pressure: full-rate sender against a long receiver hold
        idle_on = 1'b0;
        rx_hold_req++;
        set_geometry(24, 8, 3);
        queue_frame(24, 8, 3, 1'b0);
        wait_idle();

        noise_on   = 1'b1;
        work_beats = 0;
        while (work_beats < 1200) begin
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       w = '0;
                1:       w = WIDTH_REG_BITS'(1);
                2:       w = WIDTH_REG_BITS'($urandom_range(17, 64));
                default: w = WIDTH_REG_BITS'($urandom_range(2, 16));
            endcase
            h = ($urandom_range(0, 9) == 0) ? '0 : HEIGHT_REG_BITS'($urandom_range(1, 10));
            r = RADIUS_REG_BITS'($urandom_range(0, 3));
            if ($urandom_range(0, 14) == 0) rx_hold_req++;
            set_geometry(w, h, r);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
                queue_frame(w, h, r, (f == frames - 1) && ($urandom_range(0, 5) == 0));
            wait_idle();
        end
        repeat (SETTLE) @(posedge i_clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: min_filter_2d.f
sv/mf2d_pkg.sv
sv/mf2d_ctrl.sv
sv/mf2d_col_store.sv
sv/mf2d_row_min.sv
sv/min_filter_2d.sv
sim/min_filter_2d_test.sv
